// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Holds command and status codes, default sizes and the cell control struct.
// No dependencies.
package spq_pkg;

  // Default sizes
  localparam int unsigned DefCapacity = 16;
  localparam int unsigned DefKeyWidth = 32;
  localparam int unsigned DefTagWidth = 16;

  // Command carried by an input transaction
  typedef enum logic {
    CmdEnq = 1'b0,
    CmdDeq = 1'b1
  } cmd_e;

  // Status reported with each result
  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  // Per-cell update select, driven by the row control
  typedef struct packed {
    logic load_new;    // take the entry being enqueued
    logic take_left;   // take the entry of the cell in front
    logic take_right;  // take the entry of the cell behind
  } cell_ctrl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// One storage cell of the sorted priority queue row.
// Holds one entry, compares it with the incoming key and moves data to or
// from its neighbors. Depends on spq_pkg.
module spq_cell import spq_pkg::*; #(
  parameter int unsigned KEY_WIDTH = DefKeyWidth,
  parameter int unsigned TAG_WIDTH = DefTagWidth
) (
  input  logic                 clk_i,
  input  cell_ctrl_t           ctrl_i,
  input  logic                 sort_mode_i,
  input  logic                 occupied_i,
  input  logic                 run_right_i,
  input  logic [KEY_WIDTH-1:0] new_key_i,
  input  logic [KEY_WIDTH-1:0] new_ex_i,
  input  logic [KEY_WIDTH-1:0] new_de_i,
  input  logic [TAG_WIDTH-1:0] new_tag_i,
  input  logic [KEY_WIDTH-1:0] left_ex_i,
  input  logic [KEY_WIDTH-1:0] left_de_i,
  input  logic [TAG_WIDTH-1:0] left_tag_i,
  input  logic [KEY_WIDTH-1:0] right_ex_i,
  input  logic [KEY_WIDTH-1:0] right_de_i,
  input  logic [TAG_WIDTH-1:0] right_tag_i,
  output logic                 run_o,
  output logic [KEY_WIDTH-1:0] ex_o,
  output logic [KEY_WIDTH-1:0] de_o,
  output logic [TAG_WIDTH-1:0] tag_o
);

  logic [KEY_WIDTH-1:0] ex_q, de_q;
  logic [TAG_WIDTH-1:0] tag_q;
  logic [KEY_WIDTH-1:0] sel_key;
  logic                 new_smaller;

  // Compare the incoming key against the held key of the selected kind
  assign sel_key     = sort_mode_i ? de_q : ex_q;
  assign new_smaller = new_key_i < sel_key;

  // Extend the run of larger entries toward the front; an empty cell starts it
  assign run_o = occupied_i ? (new_smaller & run_right_i) : 1'b1;

  // Load, shift back or shift forward
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_new) begin
      ex_q  <= new_ex_i;
      de_q  <= new_de_i;
      tag_q <= new_tag_i;
    end else if (ctrl_i.take_left) begin
      ex_q  <= left_ex_i;
      de_q  <= left_de_i;
      tag_q <= left_tag_i;
    end else if (ctrl_i.take_right) begin
      ex_q  <= right_ex_i;
      de_q  <= right_de_i;
      tag_q <= right_tag_i;
    end
  end

  assign ex_o  = ex_q;
  assign de_o  = de_q;
  assign tag_o = tag_q;

endmodule

// ===== rtl/core/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: a row of spq_cell storage cells,
// the occupancy counter, the mode register and the result register.
// Depends on spq_pkg and spq_cell.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_stall_o   command, expiry, delivery, tag
//   out       output     out_valid_o / out_stall_i status, expiry, delivery, tag, count
//   config    input      sort_mode_we_i            sort_mode_i
//
// One transaction is taken every cycle while in_stall_o is low; its result shows in the next cycle.
// The combinational compare in each cell and the one-bit run chain through
// the row together pick the insert point.
// Reset clears the count, the mode and the result valid flag; entry storage is not cleared.
// in_stall_o is high while a result waits and out_stall_i is high.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned CAPACITY  = DefCapacity,
  parameter int unsigned KEY_WIDTH = DefKeyWidth,
  parameter int unsigned TAG_WIDTH = DefTagWidth,
  localparam int unsigned CntWidth = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 sort_mode_we_i,
  input  logic                 sort_mode_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 command_i,
  input  logic [KEY_WIDTH-1:0] expiry_key_i,
  input  logic [KEY_WIDTH-1:0] delivery_key_i,
  input  logic [TAG_WIDTH-1:0] item_tag_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [KEY_WIDTH-1:0] out_expiry_o,
  output logic [KEY_WIDTH-1:0] out_delivery_o,
  output logic [TAG_WIDTH-1:0] out_tag_o,
  output logic [CntWidth-1:0]  count_o
);

  logic                 sort_mode_q;
  logic [CntWidth-1:0]  count_q, count_d;
  logic                 out_valid_q;
  status_e              status_q, status_d;
  logic [KEY_WIDTH-1:0] res_ex_q, res_de_q, res_ex_d, res_de_d;
  logic [TAG_WIDTH-1:0] res_tag_q, res_tag_d;
  logic [CntWidth-1:0]  res_count_q;

  logic                 accept, is_deq, full, empty, enq_ok, deq_ok;
  logic [KEY_WIDTH-1:0] new_key;
  logic [CAPACITY:0]    run;

  logic [KEY_WIDTH-1:0] cell_ex  [CAPACITY];
  logic [KEY_WIDTH-1:0] cell_de  [CAPACITY];
  logic [TAG_WIDTH-1:0] cell_tag [CAPACITY];

  // Handshake
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_deq     = command_i == CmdDeq;
  assign full       = count_q == CntWidth'(CAPACITY);
  assign empty      = count_q == '0;
  assign enq_ok     = accept & ~is_deq & ~full;
  assign deq_ok     = accept & is_deq & ~empty;
  assign new_key    = sort_mode_q ? delivery_key_i : expiry_key_i;

  // Nothing lies behind the last cell
  assign run[CAPACITY] = 1'b1;

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CntWidth-1:0] Idx = CntWidth'(i);
    cell_ctrl_t           ctrl;
    logic                 run_left;
    logic [KEY_WIDTH-1:0] left_ex, left_de, right_ex, right_de;
    logic [TAG_WIDTH-1:0] left_tag, right_tag;

    if (i == 0) begin : g_front
      assign run_left = 1'b0;
      assign left_ex  = '0;
      assign left_de  = '0;
      assign left_tag = '0;
    end else begin : g_mid_front
      assign run_left = run[i-1];
      assign left_ex  = cell_ex[i-1];
      assign left_de  = cell_de[i-1];
      assign left_tag = cell_tag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_back
      assign right_ex  = '0;
      assign right_de  = '0;
      assign right_tag = '0;
    end else begin : g_mid_back
      assign right_ex  = cell_ex[i+1];
      assign right_de  = cell_de[i+1];
      assign right_tag = cell_tag[i+1];
    end

    // Insert where the run of larger entries starts; shift that run back; a dequeue shifts all forward
    assign ctrl.load_new   = enq_ok & run[i] & ~run_left;
    assign ctrl.take_left  = enq_ok & run_left & (Idx <= count_q);
    assign ctrl.take_right = deq_ok & (i != CAPACITY - 1);

    spq_cell #(
      .KEY_WIDTH(KEY_WIDTH),
      .TAG_WIDTH(TAG_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .sort_mode_i (sort_mode_q),
      .occupied_i  (Idx < count_q),
      .run_right_i (run[i+1]),
      .new_key_i   (new_key),
      .new_ex_i    (expiry_key_i),
      .new_de_i    (delivery_key_i),
      .new_tag_i   (item_tag_i),
      .left_ex_i   (left_ex),
      .left_de_i   (left_de),
      .left_tag_i  (left_tag),
      .right_ex_i  (right_ex),
      .right_de_i  (right_de),
      .right_tag_i (right_tag),
      .run_o       (run[i]),
      .ex_o        (cell_ex[i]),
      .de_o        (cell_de[i]),
      .tag_o       (cell_tag[i])
    );
  end

  // Next count and result contents
  always_comb begin
    count_d   = count_q;
    status_d  = StDone;
    res_ex_d  = '0;
    res_de_d  = '0;
    res_tag_d = '0;
    if (enq_ok) begin
      count_d = count_q + CntWidth'(1);
    end else if (deq_ok) begin
      count_d   = count_q - CntWidth'(1);
      res_ex_d  = cell_ex[0];
      res_de_d  = cell_de[0];
      res_tag_d = cell_tag[0];
    end else if (is_deq) begin
      status_d = StEmpty;
    end else begin
      status_d = StFull;
    end
  end

  // Control state: count, mode and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sort_mode_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (sort_mode_we_i) begin
        sort_mode_q <= sort_mode_i;
      end
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result payload until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q    <= status_d;
      res_ex_q    <= res_ex_d;
      res_de_q    <= res_de_d;
      res_tag_q   <= res_tag_d;
      res_count_q <= count_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_expiry_o   = res_ex_q;
  assign out_delivery_o = res_de_q;
  assign out_tag_o      = res_tag_q;
  assign count_o        = res_count_q;

endmodule

// ===== rtl/core/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker import spq_pkg::*; #(
  parameter int unsigned CAPACITY  = DefCapacity,
  parameter int unsigned KEY_WIDTH = DefKeyWidth,
  parameter int unsigned TAG_WIDTH = DefTagWidth,
  localparam int unsigned CntWidth = $clog2(CAPACITY + 1)
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 sort_mode_we_i,
  input logic                 sort_mode_i,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 command_i,
  input logic [KEY_WIDTH-1:0] expiry_key_i,
  input logic [KEY_WIDTH-1:0] delivery_key_i,
  input logic [TAG_WIDTH-1:0] item_tag_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           status_o,
  input logic [KEY_WIDTH-1:0] out_expiry_o,
  input logic [KEY_WIDTH-1:0] out_delivery_o,
  input logic [TAG_WIDTH-1:0] out_tag_o,
  input logic [CntWidth-1:0]  count_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(count_o) && $stable(status_o))
    else $error("stalled result changed");

  // Stall the input only behind a waiting, stalled result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // Report full only at capacity
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StFull |-> count_o == CntWidth'(CAPACITY))
    else $error("full status below capacity");

  // Report empty with zero count and zero payload
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StEmpty |->
      count_o == '0 && out_expiry_o == '0 && out_delivery_o == '0 && out_tag_o == '0)
    else $error("empty status with entries or payload");

  // Keep the count within capacity
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_o <= CntWidth'(CAPACITY))
    else $error("count above capacity");

endmodule

bind sorted_priority_queue spq_checker #(
  .CAPACITY  (CAPACITY),
  .KEY_WIDTH (KEY_WIDTH),
  .TAG_WIDTH (TAG_WIDTH)
) u_spq_checker (.*);
